// File: rtl/core/tmw_pkg.sv
// Shared types and constants for the text mode terminal writer.
// Screen geometry, request and response payloads, controller states and commands.
// No dependencies.
`timescale 1ns / 1ps

package tmw_pkg;

	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int CELLS  = COLS * ROWS;
	localparam int COPY_N = COLS * (ROWS - 1);
	localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] RESET_COLOUR = 8'd31;

	typedef enum logic [1:0] {
		MODE_PUT_CURSOR,
		MODE_PUT_POS,
		MODE_CLEAR,
		MODE_READ
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [7:0]       char_code;
		logic [7:0]       entry_colour;
		logic [COL_W-1:0] pos_col;
		logic [ROW_W-1:0] pos_row;
	} req_t;

	typedef struct packed {
		logic [COL_W-1:0] cursor_col;
		logic [ROW_W-1:0] cursor_row;
		logic             scrolled;
		logic             bad_position;
		logic [15:0]      cell_value;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_INIT_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL_COPY,
		ST_SCROLL_BLANK,
		ST_CLEAR,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic copy;
		logic blank;
		logic init;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic go_scroll;
		logic go_clear;
		logic copy_end;
		logic sweep_end;
	} status_t;

endpackage

// File: rtl/core/tmw_ctrl.sv
// Controller state machine for the text mode terminal writer.
// Sequences execute, scroll, clear and response steps; drives the handshakes.
// Depends on tmw_pkg.
`timescale 1ns / 1ps

module tmw_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  tmw_pkg::status_t status,
	output tmw_pkg::cmd_t    cmd
);

	tmw_pkg::state_t state_q;
	tmw_pkg::state_t state_next;
	logic            rsp_valid_q;
	logic            out_free;
	logic            ready;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign req_stall = !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tmw_pkg::ST_INIT_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_next   = state_q;
		ready        = 1'b0;
		cmd          = '0;
		unique case (state_q)
			tmw_pkg::ST_INIT_CLEAR: begin
				cmd.blank = 1'b1;
				cmd.init  = 1'b1;
				if (status.sweep_end)
					state_next = tmw_pkg::ST_IDLE;
			end
			tmw_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (req_valid)
					state_next = tmw_pkg::ST_EXEC;
			end
			tmw_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.go_scroll)
					state_next = tmw_pkg::ST_SCROLL_COPY;
				else if (status.go_clear)
					state_next = tmw_pkg::ST_CLEAR;
				else
					state_next = tmw_pkg::ST_RESULT;
			end
			tmw_pkg::ST_SCROLL_COPY: begin
				cmd.copy = 1'b1;
				if (status.copy_end)
					state_next = tmw_pkg::ST_SCROLL_BLANK;
			end
			tmw_pkg::ST_SCROLL_BLANK, tmw_pkg::ST_CLEAR: begin
				cmd.blank = 1'b1;
				if (status.sweep_end)
					state_next = tmw_pkg::ST_RESULT;
			end
			tmw_pkg::ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					ready        = 1'b1;
					state_next   = req_valid ? tmw_pkg::ST_EXEC : tmw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = tmw_pkg::ST_IDLE;
			end
		endcase
		cmd.accept = req_valid && ready;
	end

endmodule

// File: rtl/core/tmw_datapath.sv
// Datapath for the text mode terminal writer: cell memory, cursor,
// sweep counter, colour register and response register. Depends on tmw_pkg.
`timescale 1ns / 1ps

module tmw_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  tmw_pkg::req_t    req_data,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  tmw_pkg::cmd_t    cmd,
	output tmw_pkg::status_t status,
	output tmw_pkg::rsp_t    rsp_data
);

	localparam int AW = tmw_pkg::ADDR_W;
	localparam int CW = tmw_pkg::COL_W;
	localparam int RW = tmw_pkg::ROW_W;

	logic [15:0]   mem [tmw_pkg::CELLS];
	logic [15:0]   rdata_q;

	tmw_pkg::req_t req_q;
	tmw_pkg::rsp_t rsp_q;
	logic [7:0]    text_colour_q;
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [AW-1:0] cnt_q;
	logic          scr_q;
	logic          bad_q;
	logic          rd_q;

	logic          newline;
	logic          col_last;
	logic          row_last;
	logic          on_screen;
	logic          wrap;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] pos_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [7:0]    blank_colour;

	assign newline  = (req_q.char_code == tmw_pkg::NEWLINE_CODE);
	assign col_last = (cur_col_q == CW'(tmw_pkg::COLS - 1));
	assign row_last = (cur_row_q == RW'(tmw_pkg::ROWS - 1));
	assign on_screen = ({1'b0, req_q.pos_col} < (CW + 1)'(tmw_pkg::COLS))
		&& ({1'b0, req_q.pos_row} < (RW + 1)'(tmw_pkg::ROWS));
	assign wrap     = newline || col_last;
	assign cur_addr = AW'(32'(cur_row_q) * tmw_pkg::COLS + 32'(cur_col_q));
	assign pos_addr = AW'(32'(req_q.pos_row) * tmw_pkg::COLS + 32'(req_q.pos_col));
	assign blank_colour = cmd.init ? tmw_pkg::RESET_COLOUR : text_colour_q;

	assign status.go_scroll = (req_q.mode == tmw_pkg::MODE_PUT_CURSOR) && wrap && row_last;
	assign status.go_clear  = (req_q.mode == tmw_pkg::MODE_CLEAR);
	assign status.copy_end  = (cnt_q == AW'(tmw_pkg::COPY_N));
	assign status.sweep_end = (cnt_q == AW'(tmw_pkg::CELLS - 1));

	assign rsp_data = rsp_q;

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = {blank_colour, tmw_pkg::SPACE_CODE};
		re    = 1'b0;
		raddr = pos_addr;
		if (cmd.exec) begin
			if (req_q.mode == tmw_pkg::MODE_PUT_CURSOR && !newline) begin
				we    = 1'b1;
				waddr = cur_addr;
				wdata = {text_colour_q, req_q.char_code};
			end else if (req_q.mode == tmw_pkg::MODE_PUT_POS && on_screen) begin
				we    = 1'b1;
				waddr = pos_addr;
				wdata = {req_q.entry_colour, req_q.char_code};
			end
			re = (req_q.mode == tmw_pkg::MODE_READ) && on_screen;
		end else if (cmd.copy) begin
			we    = (cnt_q != '0);
			waddr = cnt_q - AW'(1);
			wdata = rdata_q;
			re    = !status.copy_end;
			raddr = cnt_q + AW'(tmw_pkg::COLS);
		end else if (cmd.blank) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			req_q <= req_data;
		if (cmd.exec) begin
			scr_q <= status.go_scroll;
			bad_q <= (req_q.mode == tmw_pkg::MODE_PUT_POS || req_q.mode == tmw_pkg::MODE_READ)
				&& !on_screen;
			rd_q  <= (req_q.mode == tmw_pkg::MODE_READ) && on_screen;
		end
		if (cmd.load_out) begin
			rsp_q.cursor_col   <= cur_col_q;
			rsp_q.cursor_row   <= cur_row_q;
			rsp_q.scrolled     <= scr_q;
			rsp_q.bad_position <= bad_q;
			rsp_q.cell_value   <= rd_q ? rdata_q : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_colour_q <= tmw_pkg::RESET_COLOUR;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			cnt_q         <= '0;
		end else begin
			if (cfg_we)
				text_colour_q <= cfg_wdata;
			if (cmd.exec) begin
				cnt_q <= '0;
				if (req_q.mode == tmw_pkg::MODE_PUT_CURSOR) begin
					if (wrap) begin
						cur_col_q <= '0;
						if (!row_last)
							cur_row_q <= cur_row_q + RW'(1);
					end else begin
						cur_col_q <= cur_col_q + CW'(1);
					end
				end else if (req_q.mode == tmw_pkg::MODE_CLEAR) begin
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
			end else if ((cmd.copy && !status.copy_end) || (cmd.blank && !status.sweep_end)) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end
	end

endmodule

// File: rtl/core/text_mode_terminal_writer.sv
// Text mode terminal writer: a COLS x ROWS store of character/colour cells with a cursor.
// An ordinary request (put at cursor, put at position, read cell) is executed against the
// single-write, single-read cell memory; the response register is then loaded once the
// output is free, and the next request is taken in that same step. A scroll adds, before
// the response, row copying and then blanking of the last row, one memory access per
// port per cycle; a clear adds blanking of every cell. After reset the block blanks the
// memory before it takes a request; colour writes are taken throughout. Depends on
// tmw_pkg, tmw_ctrl and tmw_datapath.
`timescale 1ns / 1ps

module text_mode_terminal_writer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tmw_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tmw_pkg::rsp_t rsp_data,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata
);

	tmw_pkg::cmd_t    cmd;
	tmw_pkg::status_t status;

	tmw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	tmw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.rsp_data  (rsp_data)
	);

	// an accepted request is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> cmd.exec)
		else $error("accepted request not executed");

	// a stalled response is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(rsp_valid && rsp_stall))
		else $error("response overwritten while stalled");

	// no request taken during a sweep or scroll
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy || cmd.blank) |-> req_stall)
		else $error("request taken while memory busy");

endmodule
